### src/midq_pkg.sv
// shared types, constants and helpers for the multi-input debouncer event queue
`default_nettype none
package midq_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int EVENT_DEPTH  = 16;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PTR_W  = $clog2(EVENT_DEPTH);
  localparam int CNT_W  = $clog2(EVENT_DEPTH + 1);
  localparam int ACT_W  = 4;
  localparam int ID_W   = 16;
  localparam int THR_W  = 16;
  localparam int PIN_W  = 8;
  localparam int LVL_W  = 2;
  localparam int CFG_W  = 64;
  localparam int CFG_IDX_W = 3;
  localparam int EVT_W  = ID_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDS_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDS_HIGH  = 3'd4;

  localparam logic [CFG_W-1:0] IDS_LOW_RESET  = 64'h0003_0002_0001_0000;
  localparam logic [CFG_W-1:0] IDS_HIGH_RESET = 64'h0007_0006_0005_0004;

  localparam logic [LVL_W-1:0] LEVEL_LOW     = 2'd0;
  localparam logic [LVL_W-1:0] LEVEL_HIGH    = 2'd1;
  localparam logic [LVL_W-1:0] LEVEL_UNKNOWN = 2'd2;

  localparam logic [ID_W-1:0] NO_EVENT_ID = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [PIN_W-1:0]  pins;
    logic [ID_W-1:0]   query_id;
  } cmd_t;

  typedef struct packed {
    logic              events_pending;
    logic              event_valid;
    logic [ID_W-1:0]   event_id;
    logic              event_level;
    logic [LVL_W-1:0]  query_level;
    logic              overflow;
  } res_t;

  function automatic logic [ACT_W-1:0] active_of(input logic [ACT_W-1:0] n);
    return (n > ACT_W'(NUM_CHANNELS)) ? ACT_W'(NUM_CHANNELS) : n;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(EVENT_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage
`default_nettype wire

### src/midq_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module midq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/midq_front.sv
// front end: two-entry command queue that accepts and classifies input beats
`default_nettype none
module midq_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire logic [1:0]    in_kind,
  input  wire logic [7:0]    in_pins,
  input  wire logic [15:0]   in_query_id,
  output      logic          cmd_valid,
  input  wire logic          cmd_ready,
  output      midq_pkg::cmd_t cmd
);

  midq_pkg::cmd_t entry [2];
  logic           wp;
  logic           rp;
  logic [1:0]     fill;
  logic           push;
  logic           pop;
  midq_pkg::cmd_t in_cmd;

  always_comb begin
    in_cmd.kind     = midq_pkg::kind_t'(in_kind);
    in_cmd.pins     = in_pins;
    in_cmd.query_id = in_query_id;
  end

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = entry[rp];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= in_cmd;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### src/midq_back.sv
// back end: channel debounce state, event fifo control, config and result register
`default_nettype none
module midq_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cmd_valid,
  output      logic                           cmd_ready,
  input  wire midq_pkg::cmd_t                 cmd,
  input  wire logic                           cfg_write_en,
  input  wire logic [midq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [midq_pkg::CFG_W-1:0]     cfg_data,
  output      logic                           res_valid,
  input  wire logic                           res_ready,
  output      midq_pkg::res_t                 res
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TICK = 4'b0010,
    S_POP  = 4'b0100,
    S_OUT  = 4'b1000
  } bstate_t;

  bstate_t state;

  logic [midq_pkg::ACT_W-1:0] chans;
  logic [midq_pkg::CFG_W-1:0] thr_lo;
  logic [midq_pkg::CFG_W-1:0] thr_hi;
  logic [midq_pkg::CFG_W-1:0] id_lo;
  logic [midq_pkg::CFG_W-1:0] id_hi;

  logic [midq_pkg::LVL_W-1:0] level   [midq_pkg::NUM_CHANNELS];
  logic [midq_pkg::THR_W-1:0] set_cnt [midq_pkg::NUM_CHANNELS];
  logic [midq_pkg::THR_W-1:0] rel_cnt [midq_pkg::NUM_CHANNELS];
  logic [midq_pkg::THR_W-1:0] thr_ch  [midq_pkg::NUM_CHANNELS];
  logic [midq_pkg::ID_W-1:0]  id_ch   [midq_pkg::NUM_CHANNELS];

  logic [midq_pkg::PTR_W-1:0] rd_ptr;
  logic [midq_pkg::PTR_W-1:0] wr_ptr;
  logic [midq_pkg::CNT_W-1:0] count;
  logic                       ovf;

  logic [midq_pkg::CH_W-1:0]  ch;
  midq_pkg::cmd_t             cmd_q;

  logic                       r_valid;
  logic [midq_pkg::ID_W-1:0]  r_id;
  logic                       r_level;
  logic [midq_pkg::LVL_W-1:0] r_qlev;

  logic [midq_pkg::ACT_W-1:0] active;
  logic [midq_pkg::ACT_W-1:0] new_active;
  logic [2*midq_pkg::CFG_W-1:0] thr_all;
  logic [2*midq_pkg::CFG_W-1:0] id_all;
  logic                       full;
  logic                       raw;
  logic [midq_pkg::THR_W-1:0] run;
  logic [midq_pkg::THR_W-1:0] run_inc;
  logic                       differs;
  logic                       push;
  logic                       ch_last;
  logic [midq_pkg::LVL_W-1:0] qlev;
  logic                       take;
  logic                       ram_we;
  logic                       ram_re;
  logic [midq_pkg::EVT_W-1:0] ram_wdata;
  logic [midq_pkg::EVT_W-1:0] ram_rdata;

  assign active     = midq_pkg::active_of(chans);
  assign new_active = midq_pkg::active_of(cfg_data[midq_pkg::ACT_W-1:0]);
  assign thr_all    = {thr_hi, thr_lo};
  assign id_all     = {id_hi, id_lo};
  assign full       = (count == midq_pkg::CNT_W'(midq_pkg::EVENT_DEPTH));

  always_comb begin
    for (int i = 0; i < midq_pkg::NUM_CHANNELS; i++) begin
      thr_ch[i] = thr_all[i*midq_pkg::THR_W +: midq_pkg::THR_W];
      id_ch[i]  = id_all[i*midq_pkg::ID_W +: midq_pkg::ID_W];
    end
  end

  // per-channel debounce step for the current tick channel
  always_comb begin
    raw     = cmd_q.pins[ch];
    run     = raw ? set_cnt[ch] : rel_cnt[ch];
    differs = (level[ch] != {1'b0, raw});
    run_inc = differs ? run + midq_pkg::THR_W'(1) : '0;
    push    = differs && (run >= thr_ch[ch]);
    ch_last = ((midq_pkg::ACT_W'(ch) + midq_pkg::ACT_W'(1)) == active);
  end

  // first matching channel in index order wins
  always_comb begin
    qlev = midq_pkg::LEVEL_LOW;
    for (int i = midq_pkg::NUM_CHANNELS - 1; i >= 0; i--) begin
      if ((midq_pkg::ACT_W'(i) < active) && (id_ch[i] == cmd.query_id)) begin
        qlev = level[i];
      end
    end
  end

  assign cmd_ready = (state == S_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign ram_we    = (state == S_TICK) && push && !full;
  assign ram_wdata = {id_ch[ch], raw};
  assign ram_re    = take && (cmd.kind == midq_pkg::KIND_POP) && (count != '0);

  midq_ram #(
    .WIDTH (midq_pkg::EVT_W),
    .DEPTH (midq_pkg::EVENT_DEPTH)
  ) u_event_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_q <= cmd;
    end
    if (rst) begin
      state  <= S_IDLE;
      chans  <= '0;
      thr_lo <= '0;
      thr_hi <= '0;
      id_lo  <= midq_pkg::IDS_LOW_RESET;
      id_hi  <= midq_pkg::IDS_HIGH_RESET;
      for (int i = 0; i < midq_pkg::NUM_CHANNELS; i++) begin
        level[i]   <= midq_pkg::LEVEL_UNKNOWN;
        set_cnt[i] <= '0;
        rel_cnt[i] <= '0;
      end
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      count   <= '0;
      ovf     <= 1'b0;
      ch      <= '0;
      r_valid <= 1'b0;
      r_id    <= '0;
      r_level <= 1'b0;
      r_qlev  <= midq_pkg::LEVEL_LOW;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            r_valid <= 1'b0;
            r_id    <= '0;
            r_level <= 1'b0;
            r_qlev  <= midq_pkg::LEVEL_LOW;
            ch      <= '0;
            unique case (cmd.kind)
              midq_pkg::KIND_TICK: begin
                state <= (active == '0) ? S_OUT : S_TICK;
              end
              midq_pkg::KIND_POP: begin
                if (count == '0) begin
                  r_id  <= midq_pkg::NO_EVENT_ID;
                  state <= S_OUT;
                end else begin
                  state <= S_POP;
                end
              end
              midq_pkg::KIND_QUERY: begin
                r_qlev <= qlev;
                state  <= S_OUT;
              end
              midq_pkg::KIND_NONE: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_TICK: begin
          set_cnt[ch] <= raw ? run_inc : '0;
          rel_cnt[ch] <= raw ? '0 : run_inc;
          if (push) begin
            level[ch] <= {1'b0, raw};
            if (full) begin
              ovf <= 1'b1;
            end else begin
              wr_ptr <= midq_pkg::ptr_inc(wr_ptr);
              count  <= count + midq_pkg::CNT_W'(1);
            end
          end
          if (ch_last) begin
            state <= S_OUT;
          end else begin
            ch <= ch + midq_pkg::CH_W'(1);
          end
        end
        S_POP: begin
          r_valid <= 1'b1;
          r_id    <= ram_rdata[midq_pkg::EVT_W-1:1];
          r_level <= ram_rdata[0];
          rd_ptr  <= midq_pkg::ptr_inc(rd_ptr);
          count   <= count - midq_pkg::CNT_W'(1);
          state   <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_write_en) begin
        unique case (cfg_index)
          midq_pkg::CFG_CHANNELS: begin
            chans <= cfg_data[midq_pkg::ACT_W-1:0];
            for (int i = 0; i < midq_pkg::NUM_CHANNELS; i++) begin
              if (midq_pkg::ACT_W'(i) >= new_active) begin
                level[i]   <= midq_pkg::LEVEL_UNKNOWN;
                set_cnt[i] <= '0;
                rel_cnt[i] <= '0;
              end
            end
          end
          midq_pkg::CFG_THR_LOW:  thr_lo <= cfg_data;
          midq_pkg::CFG_THR_HIGH: thr_hi <= cfg_data;
          midq_pkg::CFG_IDS_LOW:  id_lo  <= cfg_data;
          midq_pkg::CFG_IDS_HIGH: id_hi  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  assign res_valid = (state == S_OUT);

  always_comb begin
    res.events_pending = (count != '0);
    res.event_valid    = r_valid;
    res.event_id       = r_id;
    res.event_level    = r_level;
    res.query_level    = r_qlev;
    res.overflow       = ovf;
  end

endmodule
`default_nettype wire

### src/multi_input_debouncer_event_queue.sv
// top level of the multi-input debouncer with event queue
//
// Input channel (in_valid/in_ready) takes one beat per item: kind, pin_levels
// and query_id. Every item gives exactly one result beat on the output channel
// (out_valid/out_ready) with events_pending, event_valid, event_id,
// event_level, query_level and overflow.
// A two-entry command queue sits in front of the execution unit, so input
// beats are still taken while a finished result waits at the output.
// A pop goes through a registered event ram read. A tick steps through the
// channels in use one channel per cycle through a single debounce step; a
// tick with no channel in use goes straight to its result.
// The execution unit handles one item at a time and returns to idle in the
// cycle after its result is taken.
// While out_ready is low the result is held and the unit waits; the front
// queue fills up to two items, then in_ready drops.
// Reset (rst, synchronous) sets all channel levels unknown, clears counters,
// empties the event fifo, clears overflow and restores default config.
// Configuration writes (cfg_write_en) take effect at once and are to be made
// while the block is idle; the block itself does not enforce this.
`default_nettype none
module multi_input_debouncer_event_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  pin_levels,
  input  wire logic [15:0] query_id,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        events_pending,
  output      logic        event_valid,
  output      logic [15:0] event_id,
  output      logic        event_level,
  output      logic [1:0]  query_level,
  output      logic        overflow,
  input  wire logic        cfg_write_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  midq_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;
  midq_pkg::res_t res;

  midq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (kind),
    .in_pins     (pin_levels),
    .in_query_id (query_id),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  midq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .res_valid    (out_valid),
    .res_ready    (out_ready),
    .res          (res)
  );

  assign events_pending = res.events_pending;
  assign event_valid    = res.event_valid;
  assign event_id       = res.event_id;
  assign event_level    = res.event_level;
  assign query_level    = res.query_level;
  assign overflow       = res.overflow;

endmodule
`default_nettype wire
